// File: rtl/prime_count_trial_division_unit_macros.svh
// Assertion helpers for the prime counter RTL. They expect clk_i and rst_ni in scope.
`ifndef PRIME_COUNT_TRIAL_DIVISION_UNIT_MACROS_SVH
`define PRIME_COUNT_TRIAL_DIVISION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCTD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pctd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pctd assertion failed");

`endif

// File: rtl/pctd_pkg.sv
package pctd_pkg;

  // Width of the value field on the input stream.
  localparam int unsigned IN_VALUE_BITS = 16;
  // Width of the count field in a result.
  localparam int unsigned OUT_COUNT_BITS = 20;
  // Result tdata: is_prime, prime_count, padded to whole bytes.
  localparam int unsigned OUT_TDATA_BITS = ((1 + OUT_COUNT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } pctd_state_e;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } pctd_rem_stat_t;

endpackage

// File: rtl/prime_count_trial_division_unit.sv
// Trial-division prime counter.
// Input stream s_axis: tdata carries the value to test, tlast closes a list.
// Output stream m_axis: one result transaction per input transaction, with the
// prime flag and the running prime count of the list; tlast copies the input
// mark, and with it the count is final for that list.
// An input value is accepted only while the sequencer is idle. Divisors run
// from 2 up while d*d <= value; each divisor is a pass through the shared
// one-bit-per-cycle restoring remainder unit. A prime is tried against every
// such divisor, a composite stops at its smallest factor, and 0 or 1 go
// straight to the result without a division.
// The result sits in an output register, so the next value is accepted while
// a result waits; if the receiver stalls, a finished second result holds the
// sequencer until the output register frees up.
// Reset empties the output register, idles the sequencer and clears the count.
// The count saturates at 2^COUNT_BITS - 1 and is cleared after a last item.
module prime_count_trial_division_unit
  import pctd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // Fields from bit 0: value[15:0].
  input  logic [IN_VALUE_BITS-1:0]  s_axis_tdata_i,
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // Fields from bit 0: is_prime[0], prime_count[20:1], zero padding above.
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  `include "prime_count_trial_division_unit_macros.svh"

  pctd_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [VALUE_BITS:0]   sq_q, sq_d;
  logic                  prime_q, prime_d;
  logic                  last_q, last_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] count_new;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_TDATA_BITS-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;

  logic                  in_fire;
  logic                  out_free;
  logic                  rem_start;
  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] rem;
  pctd_rem_stat_t        rem_stat;

  assign v_in     = VALUE_BITS'(s_axis_tdata_i);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign count_new = (prime_q && (count_q != '1)) ? count_q + COUNT_BITS'(1) : count_q;

  pctd_rem_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(v_q),
    .divisor_i (d_q),
    .stat_o    (rem_stat),
    .rem_o     (rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (v_in < VALUE_BITS'(2)) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = (sq_q > {1'b0, v_q}) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          state_d = (rem == '0) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready_o = 1'b0;
    rem_start       = 1'b0;
    v_d             = v_q;
    d_d             = d_q;
    sq_d            = sq_q;
    prime_d         = prime_q;
    last_d          = last_q;
    count_d         = count_q;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_data_d      = out_data_q;
    out_last_d      = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          v_d     = v_in;
          last_d  = s_axis_tlast_i;
          d_d     = VALUE_BITS'(2);
          sq_d    = (VALUE_BITS + 1)'(4);
          prime_d = 1'b0;
        end
      end
      ST_CHECK: begin
        if (sq_q > {1'b0, v_q}) begin
          prime_d = 1'b1;
        end else begin
          rem_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_stat.done && (rem != '0)) begin
          // (d+1)^2 = d^2 + 2d + 1
          sq_d = sq_q + {d_q, 1'b1};
          d_d  = d_q + VALUE_BITS'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_BITS'({OUT_COUNT_BITS'(count_new), prime_q});
          out_last_d  = last_q;
          count_d     = last_q ? '0 : count_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    prime_q    <= prime_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  `PCTD_ASSERT_SAME(a_sq_tracks_divisor, state_q == ST_CHECK,
                    {{VALUE_BITS{1'b0}}, sq_q} == ({{(VALUE_BITS + 1){1'b0}}, d_q} *
                                                   {{(VALUE_BITS + 1){1'b0}}, d_q}))
  `PCTD_ASSERT_SAME(a_start_when_free, rem_start, !rem_stat.busy && state_q == ST_CHECK)
  `PCTD_ASSERT_NEXT(a_finish_waits, state_q == ST_FINISH && !out_free,
                    state_q == ST_FINISH && out_valid_q)

endmodule

// File: rtl/pctd_rem_unit.sv
module pctd_rem_unit
  import pctd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output pctd_rem_stat_t        stat_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [VALUE_BITS:0]   trial;

  // One restoring step a cycle: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, sh_q[VALUE_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(VALUE_BITS);
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = VALUE_BITS'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[VALUE_BITS-1:0];
      end
      sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// File: tb/sv/prime_count_trial_division_unit_tb.sv
`timescale 1ns / 1ps

module prime_count_trial_division_unit_tb;
  import pctd_pkg::*;

  localparam int unsigned COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam int unsigned RANDOM_ITEMS = 1730;
  localparam int unsigned HOLD_OFF_CYCLES = 6000;

  typedef struct packed {
    logic                      prime;
    logic [OUT_COUNT_BITS-1:0] count;
    logic                      done;
  } prime_result_t;

  // One directed row; the expected prime flag and count are used only when known is set.
  typedef struct packed {
    logic [IN_VALUE_BITS-1:0]  value;
    logic                      last;
    logic                      known;
    logic                      prime;
    logic [OUT_COUNT_BITS-1:0] count;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 23;

  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{16'd0,     1'b0, 1'b1, 1'b0, 20'd0},
    '{16'd1,     1'b0, 1'b1, 1'b0, 20'd0},
    '{16'd2,     1'b0, 1'b1, 1'b1, 20'd1},
    '{16'd3,     1'b0, 1'b1, 1'b1, 20'd2},
    '{16'd4,     1'b0, 1'b1, 1'b0, 20'd2},
    '{16'd65535, 1'b0, 1'b1, 1'b0, 20'd2},
    '{16'd65521, 1'b1, 1'b1, 1'b1, 20'd3},
    '{16'd0,     1'b1, 1'b1, 1'b0, 20'd0},
    '{16'd1,     1'b1, 1'b1, 1'b0, 20'd0},
    '{16'd25,    1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd49,    1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd63001, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd65025, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd32768, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd65519, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd65534, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd257,   1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd7,     1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd43690, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd21845, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd65521, 1'b0, 1'b0, 1'b0, 20'd0},
    '{16'd65521, 1'b1, 1'b0, 1'b0, 20'd0},
    '{16'd2,     1'b1, 1'b1, 1'b1, 20'd1}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_tvalid = 1'b0;
  logic [IN_VALUE_BITS-1:0]  s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tready = 1'b0;
  logic                      s_axis_tready_o;
  logic                      m_axis_tvalid_o;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic                      m_axis_tlast_o;

  prime_result_t expected_results [$];
  logic [COUNT_W-1:0] list_prime_count = '0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned list_left = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit hold_request = 1'b0;

  always #5 clk_i = ~clk_i;

  prime_count_trial_division_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic bit value_is_prime(input int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the running list count and returns the result the block should give.
  function automatic prime_result_t count_primes(input logic [IN_VALUE_BITS-1:0] v,
                                                 input logic last);
    prime_result_t r;
    r.prime = value_is_prime(int'(v));
    if (r.prime && list_prime_count != COUNT_SAT) list_prime_count = list_prime_count + 1'b1;
    r.count = list_prime_count[OUT_COUNT_BITS-1:0];
    r.done  = last;
    if (last) list_prime_count = '0;
    return r;
  endfunction

  // Most values are small so that a transaction stays short; a fifth span all 16 bits.
  function automatic logic [IN_VALUE_BITS-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 5) return IN_VALUE_BITS'($urandom_range(0, 3));
    if (k < 55) return IN_VALUE_BITS'($urandom_range(0, 255));
    if (k < 80) return IN_VALUE_BITS'($urandom_range(0, 4095));
    return IN_VALUE_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic send_value(input logic [IN_VALUE_BITS-1:0] v, input logic last,
                            input logic known, input logic prime,
                            input logic [OUT_COUNT_BITS-1:0] count);
    prime_result_t r;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = count_primes(v, last);
    if (known) begin
      r.prime = prime;
      r.count = count;
    end
    expected_results.push_back(r);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: cycles through always ready, coin flips, mostly stalled and a square wave,
  // with one long hold-off on request.
  always @(posedge clk_i) begin
    cycle_count++;
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (cycle_count[10:9])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= cycle_count[4];
      endcase
    end
  end

  always @(posedge clk_i) begin
    prime_result_t want;
    logic [OUT_TDATA_BITS-1:0] pad;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation: tdata %h tlast %b",
               m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        pad = m_axis_tdata_o >> (OUT_COUNT_BITS + 1);
        if (m_axis_tdata_o[0] !== want.prime) begin
          $error("is_prime: expected %b, actual %b", want.prime, m_axis_tdata_o[0]);
          mismatches++;
        end
        if (m_axis_tdata_o[OUT_COUNT_BITS:1] !== want.count) begin
          $error("prime_count: expected %0d, actual %0d", want.count,
                 m_axis_tdata_o[OUT_COUNT_BITS:1]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.done) begin
          $error("list_done: expected %b, actual %b", want.done, m_axis_tlast_o);
          mismatches++;
        end
        if (pad !== '0) begin
          $error("padding: expected 0, actual %h", pad);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic last;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_value(directed_rows[i].value, directed_rows[i].last, directed_rows[i].known,
                 directed_rows[i].prime, directed_rows[i].count);
    end
    wait_all_results();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Mid-run the receiver backs off long enough for the block to stall its input.
      if (n == 600) hold_request = 1'b1;
      if (n == 1200) wait_all_results();
      if (list_left == 0) begin
        list_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 20);
      end
      last = (list_left == 1);
      list_left--;
      send_value(pick_value(), last, 1'b0, 1'b0, '0);
    end

    wait_all_results();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
